FILE: rtl/vtts_pkg.sv
// Shared types, widths and codes of the virtual-time turn scheduler.
package vtts_pkg;

  localparam int ActorW = 3;
  localparam int TimeW  = 32;
  localparam int StepW  = 16;
  localparam int LenW   = 4;
  localparam int ActW   = 3;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;
  localparam int RegIdxW = AddrW - 2;

  localparam int NumActorsDef  = 6;
  localparam int MaxPreviewDef = 14;

  localparam logic [StepW-1:0] StepReset       = 16'd25600;
  localparam logic [LenW-1:0]  PreviewLenReset = 4'd14;

  localparam logic [RegIdxW-1:0] RegPreviewLen = 1'b0;

  typedef enum logic [ActW-1:0] {
    ActServe   = 3'd0,
    ActPreview = 3'd1,
    ActRetire  = 3'd2,
    ActSetStep = 3'd3,
    ActAdmit   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StAdvance
  } state_e;

  typedef enum logic {
    AluAdd,
    AluSub
  } alu_op_e;

  // Control from the sequencer to the actor table.
  typedef struct packed {
    logic              admit;
    logic              set_step;
    logic              retire;
    logic              snap;
    logic              adv_live;
    logic              adv_scratch;
    logic              use_scratch;
    logic [ActorW-1:0] wr_idx;
    logic [ActorW-1:0] scan_idx;
  } tbl_ctrl_t;

endpackage

FILE: rtl/vtts_req_if.sv
// Request channel of the turn scheduler.
interface vtts_req_if import vtts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ActW-1:0]   action;
  logic [ActorW-1:0] actor_id;
  logic [StepW-1:0]  step_amount;
  logic [TimeW-1:0]  start_time;

  modport source(output valid, action, actor_id, step_amount, start_time, input ready);
  modport sink(input valid, action, actor_id, step_amount, start_time, output ready);
endinterface

FILE: rtl/vtts_rsp_if.sv
// Result channel of the turn scheduler.
interface vtts_rsp_if import vtts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ActorW-1:0] chosen_actor;
  logic              none_alive;
  logic              last_of_run;

  modport source(output valid, chosen_actor, none_alive, last_of_run, input ready);
  modport sink(input valid, chosen_actor, none_alive, last_of_run, output ready);
endinterface

FILE: rtl/vtts_alu.sv
// Shared 32-bit adder used both for time compares and for time advances.
module vtts_alu import vtts_pkg::*; (
  input  alu_op_e          op_i,
  input  logic [TimeW-1:0] a_i,
  input  logic [TimeW-1:0] b_i,
  output logic [TimeW-1:0] sum_o
);

  logic [TimeW-1:0] b_eff;

  // Subtract is a + ~b + 1; its top bit gives the modular "earlier" test.
  assign b_eff = (op_i == AluSub) ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + TimeW'(op_i == AluSub);

endmodule

FILE: rtl/vtts_table.sv
// Per-actor storage: live times, scratch times, increments and alive marks.
module vtts_table import vtts_pkg::*; #(
  parameter int NumActors = NumActorsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_ctrl_t        ctrl_i,
  input  logic [TimeW-1:0] start_i,
  input  logic [StepW-1:0] step_i,
  input  logic [TimeW-1:0] sum_i,
  output logic [TimeW-1:0] cand_time_o,
  output logic             cand_alive_o,
  output logic [StepW-1:0] win_step_o
);

  localparam int IdxW = $clog2(NumActors);

  logic [TimeW-1:0] time_q    [NumActors];
  logic [TimeW-1:0] scratch_q [NumActors];
  logic [StepW-1:0] step_q    [NumActors];
  logic [NumActors-1:0] alive_q;

  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] scan_idx;

  assign wr_idx   = ctrl_i.wr_idx[IdxW-1:0];
  assign scan_idx = ctrl_i.scan_idx[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumActors; i++) begin
        time_q[i] <= '0;
        step_q[i] <= StepReset;
      end
      alive_q <= '0;
    end else begin
      if (ctrl_i.admit) begin
        time_q[wr_idx]  <= start_i;
        step_q[wr_idx]  <= step_i;
        alive_q[wr_idx] <= 1'b1;
      end else if (ctrl_i.adv_live) begin
        time_q[wr_idx] <= sum_i;
      end
      if (ctrl_i.set_step) begin
        step_q[wr_idx] <= step_i;
      end
      if (ctrl_i.retire) begin
        alive_q[wr_idx] <= 1'b0;
      end
    end
  end

  // Scratch copy is always fully loaded before a preview reads it.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.snap) begin
      scratch_q <= time_q;
    end else if (ctrl_i.adv_scratch) begin
      scratch_q[wr_idx] <= sum_i;
    end
  end

  assign cand_time_o  = ctrl_i.use_scratch ? scratch_q[scan_idx] : time_q[scan_idx];
  assign cand_alive_o = alive_q[scan_idx];
  assign win_step_o   = step_q[wr_idx];

endmodule

FILE: rtl/vtts_seq.sv
// Sequencer: request decode, per-actor minimum scan, time advance, result register.
module vtts_seq import vtts_pkg::*; #(
  parameter int NumActors  = NumActorsDef,
  parameter int MaxPreview = MaxPreviewDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [ActW-1:0]   req_action_i,
  input  logic [ActorW-1:0] req_actor_id_i,
  input  logic [StepW-1:0]  req_step_i,
  input  logic [LenW-1:0]   preview_len_i,
  output tbl_ctrl_t         tbl_ctrl_o,
  output logic [StepW-1:0]  tbl_step_o,
  input  logic [TimeW-1:0]  cand_time_i,
  input  logic              cand_alive_i,
  input  logic [StepW-1:0]  win_step_i,
  output alu_op_e           alu_op_o,
  output logic [TimeW-1:0]  alu_a_o,
  output logic [TimeW-1:0]  alu_b_o,
  input  logic [TimeW-1:0]  alu_sum_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output logic [ActorW-1:0] rsp_actor_o,
  output logic              rsp_none_o,
  output logic              rsp_last_o
);

  localparam int IdxW = $clog2(NumActors);
  localparam int CntW = $clog2(MaxPreview + 1);

  state_e state_q, state_d;

  logic [IdxW-1:0]  scan_q;
  logic [IdxW-1:0]  best_idx_q;
  logic [TimeW-1:0] best_time_q;
  logic             found_q;
  logic [CntW-1:0]  rem_q;
  logic             scratch_mode_q;
  logic             out_valid_q;
  logic [ActorW-1:0] out_actor_q;
  logic             out_none_q;
  logic             out_last_q;

  action_e          act;
  logic             accept;
  logic             is_run;
  logic             id_ok;
  logic             last_scan;
  logic             better;
  logic             slot_free;
  logic             adv_fire;
  logic             last_pick;
  logic [CntW-1:0]  run_len;

  assign act       = action_e'(req_action_i);
  assign accept    = req_valid_i && (state_q == StIdle);
  assign is_run    = (act == ActServe) || (act == ActPreview);
  assign id_ok     = {1'b0, req_actor_id_i} < (ActorW + 1)'(NumActors);
  assign last_scan = (scan_q == IdxW'(NumActors - 1));
  assign better    = cand_alive_i && (!found_q || alu_sum_i[TimeW-1]);
  assign slot_free = !out_valid_q || rsp_ready_i;
  assign adv_fire  = (state_q == StAdvance) && slot_free;
  assign last_pick = !found_q || (rem_q == CntW'(1));

  // Preview length: zero means one, large values saturate.
  always_comb begin
    if (preview_len_i == '0) begin
      run_len = CntW'(1);
    end else if (int'(preview_len_i) > MaxPreview) begin
      run_len = CntW'(MaxPreview);
    end else begin
      run_len = CntW'(preview_len_i);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && is_run) state_d = StScan;
      end
      StScan: begin
        if (last_scan) state_d = StAdvance;
      end
      StAdvance: begin
        if (slot_free) state_d = last_pick ? StIdle : StScan;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    req_ready_o = (state_q == StIdle);

    tbl_ctrl_o.admit       = accept && (act == ActAdmit) && id_ok;
    tbl_ctrl_o.set_step    = accept && (act == ActSetStep) && id_ok;
    tbl_ctrl_o.retire      = accept && (act == ActRetire) && id_ok;
    tbl_ctrl_o.snap        = accept && (act == ActPreview);
    tbl_ctrl_o.adv_live    = adv_fire && found_q && !scratch_mode_q;
    tbl_ctrl_o.adv_scratch = adv_fire && found_q && scratch_mode_q;
    tbl_ctrl_o.use_scratch = scratch_mode_q;
    tbl_ctrl_o.wr_idx      = (state_q == StAdvance) ? ActorW'(best_idx_q) : req_actor_id_i;
    tbl_ctrl_o.scan_idx    = ActorW'(scan_q);
    tbl_step_o             = (req_step_i == '0) ? StepW'(1) : req_step_i;

    if (state_q == StAdvance) begin
      alu_op_o = AluAdd;
      alu_a_o  = best_time_q;
      alu_b_o  = TimeW'(win_step_i);
    end else begin
      alu_op_o = AluSub;
      alu_a_o  = cand_time_i;
      alu_b_o  = best_time_q;
    end

    rsp_valid_o = out_valid_q;
    rsp_actor_o = out_actor_q;
    rsp_none_o  = out_none_q;
    rsp_last_o  = out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      scan_q         <= '0;
      found_q        <= 1'b0;
      rem_q          <= '0;
      scratch_mode_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && is_run) begin
        rem_q          <= (act == ActPreview) ? run_len : CntW'(1);
        scratch_mode_q <= (act == ActPreview);
        scan_q         <= '0;
        found_q        <= 1'b0;
      end else if (state_q == StScan) begin
        if (better) found_q <= 1'b1;
        scan_q <= last_scan ? '0 : scan_q + IdxW'(1);
      end else if (adv_fire) begin
        rem_q   <= rem_q - CntW'(1);
        found_q <= 1'b0;
      end
      if (adv_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StScan && better) begin
      best_time_q <= cand_time_i;
      best_idx_q  <= scan_q;
    end
    if (adv_fire) begin
      out_actor_q <= found_q ? ActorW'(best_idx_q) : '0;
      out_none_q  <= !found_q;
      out_last_q  <= last_pick;
    end
  end

endmodule

FILE: rtl/virtual_time_turn_scheduler_core.sv
// Virtual-time turn scheduler: each actor holds a 32-bit next-turn time, a
// 16-bit increment and an alive mark. A serve word picks the alive actor with
// the earliest time (modular compare, lowest index wins ties), returns it and
// advances that actor's time by its increment; a preview word runs the same
// picks on a scratch copy and returns preview_length results, the last one
// flagged, without touching the real schedule. Admit, retire and set-step
// words update the table and return nothing. Every pick walks the actors one
// per cycle through a single shared 32-bit adder that is also used for the
// advance. The input is not ready while a serve or preview is running; a
// finished result sits in an output register, so the next word can be
// accepted while it waits. With nobody alive, serve and preview return a
// single result with none_alive and last_of_run set. The preview_length
// register sits at byte address 0 of the APB port; zero counts as one and
// values above MAX_PREVIEW saturate.
module virtual_time_turn_scheduler_core import vtts_pkg::*; #(
  parameter int NUM_ACTORS  = NumActorsDef,
  parameter int MAX_PREVIEW = MaxPreviewDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vtts_req_if.sink          req_i,
  vtts_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  logic [LenW-1:0]  preview_len_q;
  logic             reg_hit;

  tbl_ctrl_t        tbl_ctrl;
  logic [StepW-1:0] tbl_step;
  logic [TimeW-1:0] cand_time;
  logic             cand_alive;
  logic [StepW-1:0] win_step;
  alu_op_e          alu_op;
  logic [TimeW-1:0] alu_a;
  logic [TimeW-1:0] alu_b;
  logic [TimeW-1:0] alu_sum;

  // Register decode ignores the byte offset within a 32-bit word.
  assign reg_hit = (paddr[AddrW-1:2] == RegPreviewLen);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? DataW'(preview_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preview_len_q <= PreviewLenReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      preview_len_q <= pwdata[LenW-1:0];
    end
  end

  vtts_seq #(
    .NumActors  (NUM_ACTORS),
    .MaxPreview (MAX_PREVIEW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .req_action_i   (req_i.action),
    .req_actor_id_i (req_i.actor_id),
    .req_step_i     (req_i.step_amount),
    .preview_len_i  (preview_len_q),
    .tbl_ctrl_o     (tbl_ctrl),
    .tbl_step_o     (tbl_step),
    .cand_time_i    (cand_time),
    .cand_alive_i   (cand_alive),
    .win_step_i     (win_step),
    .alu_op_o       (alu_op),
    .alu_a_o        (alu_a),
    .alu_b_o        (alu_b),
    .alu_sum_i      (alu_sum),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_actor_o    (rsp_o.chosen_actor),
    .rsp_none_o     (rsp_o.none_alive),
    .rsp_last_o     (rsp_o.last_of_run)
  );

  vtts_table #(
    .NumActors (NUM_ACTORS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tbl_ctrl),
    .start_i      (req_i.start_time),
    .step_i       (tbl_step),
    .sum_i        (alu_sum),
    .cand_time_o  (cand_time),
    .cand_alive_o (cand_alive),
    .win_step_o   (win_step)
  );

  vtts_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum)
  );

endmodule

FILE: rtl/vtts_checker.sv
// Port-level checks of the turn scheduler and their binding to the top level.
module vtts_checker import vtts_pkg::*; #(
  parameter int NumActors = NumActorsDef
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic [ActW-1:0]   req_action_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [ActorW-1:0] rsp_actor_i,
  input logic              rsp_none_i,
  input logic              rsp_last_i
);

  logic req_acc;
  logic req_run;

  assign req_acc = req_valid_i && req_ready_i;
  assign req_run = (req_action_i == ActServe) || (req_action_i == ActPreview);

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && req_run |=> !req_ready_i)
    else $error("input still ready after a serve or preview word");

  a_table_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && !req_run |=> req_ready_i)
    else $error("table word did not complete in one cycle");

  a_none_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_none_i |-> (rsp_actor_i == '0) && rsp_last_i)
    else $error("empty-schedule result is malformed");

  a_actor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ({1'b0, rsp_actor_i} < (ActorW + 1)'(NumActors)))
    else $error("chosen actor out of range");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable({rsp_actor_i, rsp_none_i, rsp_last_i}))
    else $error("stalled result word changed");

endmodule

bind virtual_time_turn_scheduler_core vtts_checker #(
  .NumActors (NUM_ACTORS)
) u_vtts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_action_i (req_i.action),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_actor_i  (rsp_o.chosen_actor),
  .rsp_none_i   (rsp_o.none_alive),
  .rsp_last_i   (rsp_o.last_of_run)
);

FILE: test/tb_top.sv
// Self-checking testbench of the virtual-time turn scheduler core.
`timescale 1ns / 1ps

module tb_top;
  import vtts_pkg::*;

  localparam int NumActors     = NumActorsDef;
  localparam int MaxPreview    = MaxPreviewDef;
  // Cycles to let pass after the last expected word before touching the register,
  // comfortably longer than a serve takes from acceptance to its result.
  localparam int SettleCycles  = 20;
  // The longest silent stretch of a correct run is one pick plus a stalled
  // result; this is many times that.
  localparam int WatchdogLimit = 2000;
  localparam int PhaseWords    = 50;

  // One request word as it goes onto the request channel.
  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [ActorW-1:0] actor_id;
    logic [StepW-1:0]  step_amount;
    logic [TimeW-1:0]  start_time;
  } sched_word_t;

  // One result word as the scheduler should return it.
  typedef struct packed {
    logic [ActorW-1:0] actor;
    logic              none;
    logic              last;
  } turn_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  vtts_req_if req_bus ();
  vtts_rsp_if rsp_bus ();

  virtual_time_turn_scheduler_core #(
    .NUM_ACTORS (NumActors),
    .MAX_PREVIEW(MaxPreview)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Words waiting to be offered, and the turns the scheduler still owes us.
  sched_word_t pending_words[$];
  turn_t       owed_turns[$];

  // Our own copy of the schedule: live times, increments, alive marks, and the
  // scratch times that a preview walks through.
  logic [TimeW-1:0] sched_time [NumActors];
  logic [StepW-1:0] sched_step [NumActors];
  logic             sched_alive[NumActors];
  logic [TimeW-1:0] look_time  [NumActors];
  logic [LenW-1:0]  preview_len_reg;

  int mismatches  = 0;
  int quiet_cycles = 0;
  // When set, neither side of the data path inserts bubbles or stalls.
  bit steady = 1'b0;

  // Index of the alive actor with the earliest time, or -1 when nobody is alive.
  // Times compare by modular difference; only a strictly earlier candidate
  // replaces the current best, so the lowest index wins a tie.
  function automatic int earliest_actor(input bit scratch);
    int               best;
    logic [TimeW-1:0] cand;
    logic [TimeW-1:0] lead;
    logic [TimeW-1:0] diff;
    best = -1;
    for (int i = 0; i < NumActors; i++) begin
      if (sched_alive[i]) begin
        if (best < 0) begin
          best = i;
        end else begin
          cand = scratch ? look_time[i] : sched_time[i];
          lead = scratch ? look_time[best] : sched_time[best];
          diff = cand - lead;
          if (diff[TimeW-1]) begin
            best = i;
          end
        end
      end
    end
    return best;
  endfunction

  function automatic void owe_turn(input int actor, input logic none, input logic last);
    turn_t t;
    t.actor = ActorW'(actor);
    t.none  = none;
    t.last  = last;
    owed_turns.push_back(t);
  endfunction

  // Applies one accepted word to our schedule and queues the turns it causes.
  function automatic void schedule_word(input sched_word_t w);
    int               best;
    int               runs;
    logic [StepW-1:0] step;
    step = (w.step_amount == '0) ? StepW'(1) : w.step_amount;
    case (w.action)
      ActServe: begin
        best = earliest_actor(1'b0);
        if (best < 0) begin
          owe_turn(0, 1'b1, 1'b1);
        end else begin
          owe_turn(best, 1'b0, 1'b1);
          sched_time[best] = sched_time[best] + TimeW'(sched_step[best]);
        end
      end
      ActPreview: begin
        // A zero length counts as one, anything above the maximum saturates.
        runs = int'(preview_len_reg);
        if (runs < 1) runs = 1;
        if (runs > MaxPreview) runs = MaxPreview;
        for (int i = 0; i < NumActors; i++) look_time[i] = sched_time[i];
        if (earliest_actor(1'b1) < 0) begin
          owe_turn(0, 1'b1, 1'b1);
        end else begin
          for (int k = 0; k < runs; k++) begin
            best = earliest_actor(1'b1);
            owe_turn(best, 1'b0, k == runs - 1);
            look_time[best] = look_time[best] + TimeW'(sched_step[best]);
          end
        end
      end
      ActRetire: begin
        if (w.actor_id < NumActors) sched_alive[w.actor_id] = 1'b0;
      end
      ActSetStep: begin
        if (w.actor_id < NumActors) sched_step[w.actor_id] = step;
      end
      ActAdmit: begin
        if (w.actor_id < NumActors) begin
          sched_time[w.actor_id]  = w.start_time;
          sched_step[w.actor_id]  = step;
          sched_alive[w.actor_id] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Request driver. A new word is offered only once the previous one has been
  // taken, so valid is assigned at most once per edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!req_bus.valid || req_bus.ready) begin
        if (req_bus.valid) begin
          schedule_word({req_bus.action, req_bus.actor_id, req_bus.step_amount,
                         req_bus.start_time});
        end
        if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 9)) begin
          req_bus.valid       <= 1'b1;
          req_bus.action      <= pending_words[0].action;
          req_bus.actor_id    <= pending_words[0].actor_id;
          req_bus.step_amount <= pending_words[0].step_amount;
          req_bus.start_time  <= pending_words[0].start_time;
          void'(pending_words.pop_front());
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every accepted result is checked against the oldest owed
  // turn, field by field; ready stalls at random unless steady is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (owed_turns.size() == 0) begin
          $display("%0t: expected no result, got actor %0d none %0b last %0b", $realtime,
                   rsp_bus.chosen_actor, rsp_bus.none_alive, rsp_bus.last_of_run);
          mismatches++;
        end else begin
          if (rsp_bus.chosen_actor !== owed_turns[0].actor) begin
            $display("%0t: chosen_actor expected %0d got %0d", $realtime,
                     owed_turns[0].actor, rsp_bus.chosen_actor);
            mismatches++;
          end
          if (rsp_bus.none_alive !== owed_turns[0].none) begin
            $display("%0t: none_alive expected %0b got %0b", $realtime,
                     owed_turns[0].none, rsp_bus.none_alive);
            mismatches++;
          end
          if (rsp_bus.last_of_run !== owed_turns[0].last) begin
            $display("%0t: last_of_run expected %0b got %0b", $realtime,
                     owed_turns[0].last, rsp_bus.last_of_run);
            mismatches++;
          end
          void'(owed_turns.pop_front());
        end
      end
      rsp_bus.ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  // Watchdog: any handshake or register access counts as progress.
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic push_word(input logic [ActW-1:0] action, input int id,
                           input int step, input logic [TimeW-1:0] start);
    sched_word_t w;
    w.action      = action;
    w.actor_id    = ActorW'(id);
    w.step_amount = StepW'(step);
    w.start_time  = start;
    pending_words.push_back(w);
  endtask

  // Writes preview_length over APB, reads it back, and updates our copy. Only
  // called while the data path is idle.
  task automatic set_preview_length(input logic [LenW-1:0] value);
    logic [AddrW-1:0] addr;
    addr = AddrW'(RegPreviewLen) << 2;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    preview_len_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[LenW-1:0] !== value) begin
      $display("%0t: preview_length readback expected %0d got %0d", $realtime,
               value, prdata[LenW-1:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Increments: mostly wide random values, with zero, tiny steps that pile up
  // ties, and the maximum mixed in.
  function automatic int pick_step();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 30) return $urandom_range(4, 1);
    if (r < 38) return 65535;
    return $urandom_range(65535);
  endfunction

  // Start times: random, just below the wrap, small, or one shared value so
  // that admitted actors collide.
  function automatic logic [TimeW-1:0] pick_start();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return 32'hFFFF_0000 | TimeW'($urandom_range(65535));
      2:       return TimeW'($urandom_range(255));
      default: return 32'h0000_1000;
    endcase
  endfunction

  // Random words for one phase. Each phase opens with everyone retiring and a
  // serve and preview against the empty table, then mostly admits and serves
  // with some noise: out-of-range actors and unknown actions, which the
  // scheduler drops and which do not count toward the phase size.
  task automatic queue_random_words(input int count);
    int          made;
    int          r;
    sched_word_t w;
    made = 0;
    for (int i = 0; i < NumActors; i++) push_word(ActRetire, i, pick_step(), $urandom());
    push_word(ActServe, $urandom_range(7), pick_step(), $urandom());
    push_word(ActPreview, $urandom_range(7), pick_step(), $urandom());
    while (made < count) begin
      r             = $urandom_range(99);
      w.actor_id    = ActorW'($urandom_range(NumActors - 1));
      w.step_amount = StepW'(pick_step());
      w.start_time  = pick_start();
      made++;
      if (r < 34) begin
        w.action = ActServe;
      end else if (r < 44) begin
        w.action = ActPreview;
      end else if (r < 64) begin
        w.action = ActAdmit;
      end else if (r < 72) begin
        w.action = ActRetire;
      end else if (r < 82) begin
        w.action = ActSetStep;
      end else if (r < 88) begin
        w.action   = ActW'(ActRetire + $urandom_range(2));
        w.actor_id = ActorW'($urandom_range(7, NumActors));
        made--;
      end else if (r < 91) begin
        w.action = ActW'($urandom_range(7, ActAdmit + 1));
        made--;
      end else begin
        w.action = ActServe;
      end
      pending_words.push_back(w);
    end
  endtask

  // Blocks until every word has been taken and every owed turn has come back,
  // then lets the settle time pass for table words still in flight.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || req_bus.valid || owed_turns.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [LenW-1:0] phase_len[6];
    phase_len = '{4'd1, 4'd0, 4'd15, 4'd7, 4'd14, 4'd0};
    phase_len[5] = LenW'($urandom_range(13, 2));

    // Every input of the block sits at a known value from time zero.
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_bus.valid       = 1'b0;
    req_bus.action      = '0;
    req_bus.actor_id    = '0;
    req_bus.step_amount = '0;
    req_bus.start_time  = '0;
    rsp_bus.ready       = 1'b0;

    for (int i = 0; i < NumActors; i++) begin
      sched_time[i]  = '0;
      sched_step[i]  = StepReset;
      sched_alive[i] = 1'b0;
      look_time[i]   = '0;
    end
    preview_len_reg = PreviewLenReset;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the longest preview. The table starts empty, so the
    // first serve and preview must come back with none_alive set.
    set_preview_length(4'd14);
    push_word(ActServe, 7, 65535, 32'hFFFF_FFFF);
    push_word(ActPreview, 0, 0, 32'h0);
    // Zero step is stored as one; start time at its maximum.
    push_word(ActAdmit, 0, 0, 32'hFFFF_FFFF);
    push_word(ActAdmit, NumActors - 1, 65535, 32'h0);
    // Actor ids past the table and unknown actions are dropped.
    push_word(ActAdmit, 6, 1, 32'h0);
    push_word(ActAdmit, 7, 65535, 32'hFFFF_FFFF);
    push_word(ActSetStep, 7, 1, 32'h0);
    push_word(ActRetire, 6, 0, 32'hFFFF_FFFF);
    push_word(ActW'(ActAdmit + 1), 0, 65535, 32'h5A5A_A5A5);
    push_word(ActW'(ActAdmit + 2), 3, 1, 32'hA5A5_5A5A);
    push_word(ActW'(ActAdmit + 3), 7, 0, 32'hFFFF_FFFF);
    // Actor 0 wraps through zero and then ties with the last actor.
    push_word(ActServe, 0, 0, 32'h0);
    push_word(ActServe, 7, 65535, 32'hFFFF_FFFF);
    push_word(ActPreview, 5, 1234, 32'h1234_5678);
    push_word(ActSetStep, 0, 65535, 32'h0);
    push_word(ActAdmit, 2, 1, 32'h0);
    // Half the time circle away: the modular order is not transitive here.
    push_word(ActAdmit, 3, 25600, 32'h8000_0000);
    push_word(ActPreview, 0, 0, 32'h0);
    push_word(ActServe, 1, 2, 32'h3);
    push_word(ActServe, 2, 3, 32'h4);
    push_word(ActServe, 3, 4, 32'h5);
    push_word(ActRetire, 0, 0, 32'h0);
    push_word(ActRetire, NumActors - 1, 0, 32'h0);
    push_word(ActRetire, 2, 0, 32'h0);
    push_word(ActRetire, 3, 0, 32'h0);
    push_word(ActServe, 0, 0, 32'h0);
    wait_drained();

    // Random phases, each at its own preview length, the extremes included.
    // The fourth phase runs without bubbles or stalls on either side.
    for (int p = 0; p < 6; p++) begin
      set_preview_length(phase_len[p]);
      steady = (p == 3);
      queue_random_words(PhaseWords);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
